[design/nested_record_byte_swapper_macros.svh]
// Assertion macros shared by the checker of the record byte swapper.
// Depends on nothing; included by the checker file.
`ifndef NESTED_RECORD_BYTE_SWAPPER_MACROS_SVH
`define NESTED_RECORD_BYTE_SWAPPER_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define NRBS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define NRBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[design/nrbs_pkg.sv]
// Package of the record byte swapper: widths, type codes and helper functions.
// Depends on nothing; used by the controller, datapath and top level.
package nrbs_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int POS_BITS = 32;
   localparam int LVL_BITS = $clog2(MAX_DEPTH + 1);
   localparam int IDX_BITS = $clog2(MAX_DEPTH);

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [LVL_BITS-1:0] lvl_type;

   localparam logic [2:0] PH_WAIT = 3'd0;
   localparam logic [2:0] PH_BODY = 3'd1;
   localparam logic [2:0] PH_BANK1 = 3'd2;
   localparam logic [2:0] PH_BANK2 = 3'd3;
   localparam logic [2:0] PH_BANK3 = 3'd4;
   localparam logic [2:0] PH_SEG1 = 3'd5;

   localparam logic [7:0] K_TAGSEG = 8'h0c;
   localparam logic [7:0] K_SEG = 8'h0d;
   localparam logic [7:0] K_BANK = 8'h0e;
   localparam logic [7:0] K_BANK2 = 8'h10;
   localparam logic [7:0] K_SEG2 = 8'h20;
   localparam logic [7:0] K_TAGSEG2 = 8'h40;
   localparam logic [7:0] K_FULL = 8'hff;

   // Controller commands to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic pop;
   } cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic top_ends;
      logic has_out;
   } stat_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_POP = 4'b0010,
      ST_STEP = 4'b0100,
      ST_OUT = 4'b1000
   } state_type;

   function automatic logic [15:0] swap16(input logic [15:0] x);
      return {x[7:0], x[15:8]};
   endfunction

   // Zero unknown, one plain, otherwise unit halfwords plus one.
   function automatic logic [2:0] unit_code(input logic [7:0] t);
      logic [2:0] c;
      unique case (t)
         8'h00, 8'h03, 8'h06, 8'h07, 8'h36, 8'h37: c = 3'd1;
         8'h04, 8'h05, 8'h30, 8'h34, 8'h35: c = 3'd2;
         8'h01, 8'h02, 8'h0b, 8'h0f: c = 3'd3;
         8'h08, 8'h09, 8'h0a: c = 3'd5;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic wide_container(input logic [7:0] t);
      return t >= 8'h10 || t == K_TAGSEG || t == K_SEG || t == K_BANK;
   endfunction

endpackage

[design/nrbs_ctrl.sv]
// Controller of the record byte swapper: handshake, stack pops, result drain.
// Depends on nrbs_pkg.
module nrbs_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic rsp_stall,
   input logic [2:0] out_count,
   input nrbs_pkg::stat_type stat,
   output nrbs_pkg::cmd_type cmd,
   output logic [1:0] out_sel,
   output logic rsp_valid
);

   nrbs_pkg::state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   assign req_stall = state_ff != nrbs_pkg::ST_IDLE;
   assign rsp_valid = state_ff == nrbs_pkg::ST_OUT;
   assign out_sel = sel_ff;

   // Sequence: accept, pop closed levels, step, then drain the results, if any.
   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cmd = '0;
      unique case (state_ff)
         nrbs_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = nrbs_pkg::ST_POP;
            end
         end
         nrbs_pkg::ST_POP: begin
            if (stat.top_ends) begin
               cmd.pop = 1'b1;
            end else begin
               state_in = nrbs_pkg::ST_STEP;
            end
         end
         nrbs_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            sel_in = '0;
            state_in = stat.has_out ? nrbs_pkg::ST_OUT : nrbs_pkg::ST_IDLE;
         end
         nrbs_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               if ({1'b0, sel_ff} + 3'd1 >= out_count) begin
                  state_in = nrbs_pkg::ST_IDLE;
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end
         end
         default: state_in = nrbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrbs_pkg::ST_IDLE;
         sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
      end
   end

endmodule

[design/nrbs_datapath.sv]
// Datapath of the record byte swapper: parse state, stack and result buffer.
// Depends on nrbs_pkg.
module nrbs_datapath (
   input logic clock,
   input logic reset,
   input logic [15:0] req_in_half,
   input nrbs_pkg::cmd_type cmd,
   input logic [1:0] out_sel,
   output nrbs_pkg::stat_type stat,
   output logic [2:0] out_count,
   output logic [15:0] rsp_out_half,
   output logic rsp_run_last,
   output logic rsp_event_end,
   output logic rsp_bad_type
);

   localparam nrbs_pkg::pos_type POS_ONE = nrbs_pkg::pos_type'(1);
   localparam nrbs_pkg::pos_type POS_TWO = nrbs_pkg::pos_type'(2);

   nrbs_pkg::pos_type end_mem [nrbs_pkg::MAX_DEPTH];
   logic [7:0] kind_mem [nrbs_pkg::MAX_DEPTH];

   nrbs_pkg::lvl_type level_ff, level_in;
   nrbs_pkg::pos_type pos_ff, pos_in, nha_ff, nha_in, lim_ff, lim_in;
   logic [7:0] kind_ff, kind_in;
   logic [15:0] half_ff, half_in;
   logic [15:0] hold_ff [3];
   logic [15:0] hold_in [3];
   logic [1:0] hcnt_ff, hcnt_in;
   logic [2:0] phase_ff, phase_in;
   logic [15:0] obuf_ff [4];
   logic [15:0] obuf_in [4];
   logic [3:0] obad_ff, obad_in;
   logic [2:0] ocnt_ff, ocnt_in;
   logic oend_ff, oend_in;

   logic push;
   nrbs_pkg::pos_type push_end;
   logic [7:0] push_kind;
   nrbs_pkg::lvl_type top_idx;

   // The accepted beat is captured and held until the step.
   assign half_in = cmd.load ? req_in_half : half_ff;

   // Closed levels are popped only while the body is parsed.
   assign top_idx = level_ff - nrbs_pkg::lvl_type'(1);
   assign stat.top_ends = phase_ff == nrbs_pkg::PH_BODY && level_ff != '0 &&
      end_mem[top_idx[nrbs_pkg::IDX_BITS-1:0]] == pos_ff;
   assign stat.has_out = ocnt_in != '0;

   assign out_count = ocnt_ff;
   assign rsp_out_half = obuf_ff[out_sel];
   assign rsp_bad_type = obad_ff[out_sel];
   assign rsp_run_last = {1'b0, out_sel} + 3'd1 == ocnt_ff;
   assign rsp_event_end = rsp_run_last && oend_ff;

   // Per-item parse step, following the record layout.
   always_comb begin
      logic [15:0] cur;
      nrbs_pkg::pos_type p, ep, e, v8;
      logic [31:0] w;
      logic [7:0] t, parent;
      logic [2:0] code;
      logic cont, child, open;
      logic [1:0] k;
      cur = half_ff;
      p = pos_ff;
      level_in = level_ff;
      pos_in = pos_ff;
      nha_in = nha_ff;
      lim_in = lim_ff;
      kind_in = kind_ff;
      hold_in = hold_ff;
      hcnt_in = hcnt_ff;
      phase_in = phase_ff;
      obuf_in = obuf_ff;
      obad_in = obad_ff;
      ocnt_in = ocnt_ff;
      oend_in = oend_ff;
      push = 1'b0;
      push_end = '0;
      push_kind = '0;
      w = {nrbs_pkg::swap16(hold_ff[0]), nrbs_pkg::swap16(cur)};
      t = '0;
      parent = '0;
      code = '0;
      cont = 1'b0;
      child = 1'b0;
      open = 1'b0;
      ep = '0;
      e = '0;
      v8 = '0;
      k = '0;
      if (cmd.pop) begin
         level_in = level_ff - nrbs_pkg::lvl_type'(1);
      end else if (cmd.step) begin
         ocnt_in = '0;
         obad_in = '0;
         oend_in = 1'b0;
         unique case (phase_ff)
            nrbs_pkg::PH_BODY: begin
               if (p == nha_ff) begin
                  parent = level_ff != '0 ? kind_mem[top_idx[nrbs_pkg::IDX_BITS-1:0]]
                     : 8'h00;
                  hcnt_in = '0;
                  if (parent == nrbs_pkg::K_BANK || parent == nrbs_pkg::K_BANK2) begin
                     hold_in[0] = cur;
                     hcnt_in = 2'd1;
                     phase_in = nrbs_pkg::PH_BANK1;
                  end else if (parent == nrbs_pkg::K_SEG || parent == nrbs_pkg::K_SEG2
                        || parent == nrbs_pkg::K_TAGSEG
                        || parent == nrbs_pkg::K_TAGSEG2) begin
                     hold_in[0] = cur;
                     hcnt_in = 2'd1;
                     kind_in = parent;
                     phase_in = nrbs_pkg::PH_SEG1;
                  end else begin
                     obuf_in[0] = nrbs_pkg::swap16(cur);
                     ocnt_in = 3'd1;
                     if (nrbs_pkg::swap16(cur) == 16'h0000) begin
                        nha_in = p + POS_ONE;
                     end else begin
                        kind_in = parent;
                        v8 = nrbs_pkg::pos_type'(cur[15:8]);
                        nha_in = p + v8 + POS_ONE;
                     end
                  end
               end else begin
                  code = nrbs_pkg::unit_code(kind_ff);
                  if (code == 3'd0 || code == 3'd1) begin
                     obuf_in[0] = cur;
                     obad_in[0] = code == 3'd0;
                     ocnt_in = 3'd1;
                  end else if ({1'b0, hcnt_ff} + 3'd1 >= code - 3'd1) begin
                     // Unit complete: reverse and swap.
                     obuf_in[0] = nrbs_pkg::swap16(cur);
                     for (int i = 0; i < 3; i++) begin
                        k = hcnt_ff - 2'(i) - 2'd1;
                        if (2'(i) < hcnt_ff) obuf_in[i+1] = nrbs_pkg::swap16(hold_ff[k]);
                     end
                     ocnt_in = {1'b0, hcnt_ff} + 3'd1;
                     hcnt_in = '0;
                  end else begin
                     hold_in[hcnt_ff] = cur;
                     hcnt_in = hcnt_ff + 2'd1;
                  end
                  // A region that ends mid-unit flushes plain.
                  if (p + POS_ONE == nha_ff && hcnt_in != '0) begin
                     for (int i = 0; i < 3; i++) begin
                        if (2'(i) < hcnt_in) obuf_in[i] = hold_in[i];
                     end
                     ocnt_in = {1'b0, hcnt_in};
                     hcnt_in = '0;
                  end
               end
            end
            nrbs_pkg::PH_BANK1: begin
               obuf_in[0] = nrbs_pkg::swap16(cur);
               obuf_in[1] = nrbs_pkg::swap16(hold_ff[0]);
               ocnt_in = 3'd2;
               hcnt_in = '0;
               e = p - POS_ONE + nrbs_pkg::pos_type'({w, 1'b0}) + POS_TWO;
               nha_in = e;
               if (p == POS_ONE) lim_in = e;
               phase_in = nrbs_pkg::PH_BANK2;
            end
            nrbs_pkg::PH_BANK2: begin
               hold_in[0] = cur;
               hcnt_in = 2'd1;
               phase_in = nrbs_pkg::PH_BANK3;
            end
            nrbs_pkg::PH_BANK3, nrbs_pkg::PH_SEG1: begin
               obuf_in[0] = nrbs_pkg::swap16(cur);
               obuf_in[1] = nrbs_pkg::swap16(hold_ff[0]);
               ocnt_in = 3'd2;
               open = 1'b1;
               if (phase_ff == nrbs_pkg::PH_BANK3) begin
                  t = w[15:8];
                  ep = nha_ff;
                  child = nrbs_pkg::wide_container(t);
               end else begin
                  ep = p - POS_ONE + nrbs_pkg::pos_type'({w[15:0], 1'b0}) + POS_TWO;
                  if (kind_ff == nrbs_pkg::K_TAGSEG || kind_ff == nrbs_pkg::K_TAGSEG2)
                        begin
                     t = {4'h0, w[19:16]};
                     child = t == nrbs_pkg::K_TAGSEG || t == nrbs_pkg::K_SEG
                        || t == nrbs_pkg::K_BANK;
                  end else begin
                     t = w[23:16];
                     child = nrbs_pkg::wide_container(t);
                  end
               end
            end
            default: begin
               level_in = '0;
               hold_in[0] = cur;
               hcnt_in = 2'd1;
               phase_in = nrbs_pkg::PH_BANK1;
            end
         endcase
         // After a full header, open a child structure if it fits on the stack, else take its body as data.
         if (open) begin
            cont = child && level_ff < nrbs_pkg::lvl_type'(nrbs_pkg::MAX_DEPTH);
            if (child && cont) begin
               push = 1'b1;
               push_end = ep;
               push_kind = t;
               level_in = level_ff + nrbs_pkg::lvl_type'(1);
               nha_in = p + POS_ONE;
            end else begin
               kind_in = child ? nrbs_pkg::K_FULL : t;
               nha_in = ep;
            end
            hcnt_in = '0;
            phase_in = nrbs_pkg::PH_BODY;
         end
         if (phase_ff == nrbs_pkg::PH_BODY || phase_ff == nrbs_pkg::PH_BANK1
               || phase_ff == nrbs_pkg::PH_BANK2 || phase_ff == nrbs_pkg::PH_BANK3
               || phase_ff == nrbs_pkg::PH_SEG1) begin
            pos_in = p + POS_ONE;
            // Event end: flush held halfwords and return to waiting.
            if (pos_in == lim_in) begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < hcnt_in) obuf_in[2'(3'(i) + ocnt_in)] = hold_in[i];
               end
               ocnt_in = ocnt_in + {1'b0, hcnt_in};
               hcnt_in = '0;
               level_in = '0;
               pos_in = '0;
               nha_in = '0;
               kind_in = '0;
               phase_in = nrbs_pkg::PH_WAIT;
               oend_in = 1'b1;
            end
         end else begin
            pos_in = POS_ONE;
         end
      end
   end

   // Stack memory writes.
   always_ff @(posedge clock) begin
      if (push) begin
         end_mem[level_ff[nrbs_pkg::IDX_BITS-1:0]] <= push_end;
         kind_mem[level_ff[nrbs_pkg::IDX_BITS-1:0]] <= push_kind;
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         pos_ff <= '0;
         nha_ff <= '0;
         lim_ff <= '0;
         kind_ff <= '0;
         hcnt_ff <= '0;
         phase_ff <= nrbs_pkg::PH_WAIT;
         ocnt_ff <= '0;
         oend_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
         pos_ff <= pos_in;
         nha_ff <= nha_in;
         lim_ff <= lim_in;
         kind_ff <= kind_in;
         hcnt_ff <= hcnt_in;
         phase_ff <= phase_in;
         ocnt_ff <= ocnt_in;
         oend_ff <= oend_in;
      end
      half_ff <= half_in;
      hold_ff <= hold_in;
      obuf_ff <= obuf_in;
      obad_ff <= obad_in;
   end

endmodule

[design/nested_record_byte_swapper.sv]
// Top level of the record byte swapper.
// Depends on nrbs_pkg, nrbs_ctrl and nrbs_datapath.
//
// Usage: the req channel takes one 16-bit halfword of an event record per
// beat, in big-endian byte order. The rsp channel returns zero to four
// halfwords per input beat in native order, with run_last on the last one
// of the beat, event_end when that beat closed the event, and bad_type on
// data of an unknown type or of a container that could not be stacked.
// One input beat is accepted, then the controller pops every nesting level
// that closes at the current position (one pop at a time, then one check),
// steps the parser once and drains the results one per cycle while rsp is
// not stalled. Stall on rsp holds the current result and the req channel
// stalls until the beat is fully drained.
// Reset is synchronous: parser waits for an event length word, the stack
// is empty and no result is pending.
module nested_record_byte_swapper (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [15:0] req_in_half,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [15:0] rsp_out_half,
   output logic rsp_run_last,
   output logic rsp_event_end,
   output logic rsp_bad_type
);

   nrbs_pkg::cmd_type cmd;
   nrbs_pkg::stat_type stat;
   logic [2:0] out_count;
   logic [1:0] out_sel;

   nrbs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_stall(rsp_stall), .out_count(out_count), .stat(stat), .cmd(cmd),
      .out_sel(out_sel), .rsp_valid(rsp_valid)
   );

   nrbs_datapath u_dp (
      .clock(clock), .reset(reset), .req_in_half(req_in_half), .cmd(cmd),
      .out_sel(out_sel), .stat(stat), .out_count(out_count),
      .rsp_out_half(rsp_out_half), .rsp_run_last(rsp_run_last),
      .rsp_event_end(rsp_event_end), .rsp_bad_type(rsp_bad_type)
   );

endmodule

[design/nrbs_checker.sv]
// Port checker of the record byte swapper, bound to the top level.
// Depends on nested_record_byte_swapper_macros.svh.
`include "nested_record_byte_swapper_macros.svh"
module nrbs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_run_last,
   input logic rsp_event_end
);
   // A result is never shown while an input beat can be taken.
   `NRBS_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, req_stall)
   // Event end marks only the last result of a beat.
   `NRBS_ASSERT_SAME(a_end_last, clock, reset, rsp_valid && rsp_event_end, rsp_run_last)
   // A stalled result stays valid.
   `NRBS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // After an accepted beat the block is busy.
   `NRBS_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind nested_record_byte_swapper nrbs_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_run_last(rsp_run_last),
   .rsp_event_end(rsp_event_end)
);

[verif/nested_record_byte_swapper_tb.sv]
// Self-checking testbench of the nested record byte swapper.
// Depends on nrbs_pkg and the nested_record_byte_swapper RTL. It builds nested
// event records at random, predicts every output beat and checks each one.
module nested_record_byte_swapper_tb;

   typedef bit [15:0] half_q_type[$];

   // One expected output beat.
   typedef struct {
      bit [15:0] half;
      bit run_last;
      bit event_end;
      bit bad_type;
   } swap_beat_type;

   // Swaps the two bytes of a halfword.
   function automatic bit [15:0] flip(input bit [15:0] x);
      return {x[7:0], x[15:8]};
   endfunction

   // Data swap width: 0 unknown type, 1 unswapped, else unit halfwords plus one.
   function automatic int swap_width(input bit [7:0] t);
      case (t)
         8'h00, 8'h03, 8'h06, 8'h07, 8'h36, 8'h37: return 1;
         8'h04, 8'h05, 8'h30, 8'h34, 8'h35: return 2;
         8'h01, 8'h02, 8'h0b, 8'h0f: return 3;
         8'h08, 8'h09, 8'h0a: return 5;
         default: return 0;
      endcase
   endfunction

   function automatic bit holds_children(input bit [7:0] t);
      return t >= nrbs_pkg::K_BANK2 || t == nrbs_pkg::K_TAGSEG || t == nrbs_pkg::K_SEG
         || t == nrbs_pkg::K_BANK;
   endfunction

   class swap_scoreboard;
      bit [nrbs_pkg::POS_BITS-1:0] end_stk[nrbs_pkg::MAX_DEPTH];
      bit [7:0] kind_stk[nrbs_pkg::MAX_DEPTH];
      int unsigned level;
      bit [nrbs_pkg::POS_BITS-1:0] pos, header_pos, event_len;
      bit [7:0] data_type;
      bit [15:0] hold[3];
      int unsigned hold_n;
      logic [2:0] phase;
      swap_beat_type step_beats[$];
      swap_beat_type pending[$];
      int errors;

      function void clear_hold();
         hold_n = 0;
         foreach (hold[k]) hold[k] = '0;
      endfunction

      function void reset_state();
         level = 0;
         pos = '0;
         header_pos = '0;
         event_len = '0;
         data_type = '0;
         clear_hold();
         phase = nrbs_pkg::PH_WAIT;
         pending.delete();
         errors = 0;
      endfunction

      function void push_hold(input bit [15:0] v);
         if (hold_n < 3) begin
            hold[hold_n] = v;
            hold_n++;
         end
      endfunction

      function void emit(input bit [15:0] v, input bit bad);
         swap_beat_type b;
         b.half = v;
         b.run_last = 0;
         b.event_end = 0;
         b.bad_type = bad;
         step_beats.push_back(b);
      endfunction

      // Held halfwords plus the current one, in reverse order, each swapped.
      function void emit_unit(input bit [15:0] cur);
         emit(flip(cur), 0);
         for (int k = int'(hold_n) - 1; k >= 0; k--) emit(flip(hold[k]), 0);
         clear_hold();
      endfunction

      function void flush_held();
         for (int k = 0; k < int'(hold_n); k++) emit(hold[k], 0);
         clear_hold();
      endfunction

      function bit [31:0] header_word(input bit [15:0] cur);
         return {flip(hold[0]), flip(cur)};
      endfunction

      function bit [nrbs_pkg::POS_BITS-1:0] span_end(input bit [nrbs_pkg::POS_BITS-1:0] p,
                                                     input bit [31:0] len);
         return p + 2 * len + 1;
      endfunction

      function void open_child(input bit [nrbs_pkg::POS_BITS-1:0] stop, input bit [7:0] t,
                               input bit nested, input bit [nrbs_pkg::POS_BITS-1:0] p);
         if (nested && level < nrbs_pkg::MAX_DEPTH) begin
            end_stk[level] = stop;
            kind_stk[level] = t;
            level++;
            header_pos = p + 1;
         end else begin
            // A container that does not fit on the stack passes as unknown data.
            data_type = nested ? nrbs_pkg::K_FULL : t;
            header_pos = stop;
         end
         clear_hold();
         phase = nrbs_pkg::PH_BODY;
      endfunction

      function void body_beat(input bit [15:0] cur, input bit [nrbs_pkg::POS_BITS-1:0] p);
         bit [7:0] parent;
         bit [15:0] v;
         int w;
         while (level > 0 && end_stk[level-1] == p) level--;
         if (p == header_pos) begin
            parent = level > 0 ? kind_stk[level-1] : 8'h00;
            clear_hold();
            if (parent == nrbs_pkg::K_BANK || parent == nrbs_pkg::K_BANK2) begin
               push_hold(cur);
               phase = nrbs_pkg::PH_BANK1;
            end else if (parent == nrbs_pkg::K_SEG || parent == nrbs_pkg::K_SEG2 ||
                         parent == nrbs_pkg::K_TAGSEG || parent == nrbs_pkg::K_TAGSEG2) begin
               push_hold(cur);
               data_type = parent;
               phase = nrbs_pkg::PH_SEG1;
            end else begin
               // Packet header: zero is an empty packet.
               v = flip(cur);
               emit(v, 0);
               if (v == 0) begin
                  header_pos = p + 1;
               end else begin
                  data_type = parent;
                  header_pos = p + v[7:0] + 1;
               end
            end
            return;
         end
         w = swap_width(data_type);
         if (w == 0) begin
            emit(cur, 1);
         end else if (w == 1) begin
            emit(cur, 0);
         end else if (hold_n + 1 >= w - 1) begin
            emit_unit(cur);
         end else begin
            push_hold(cur);
         end
         if (p + 1 == header_pos && hold_n > 0) flush_held();
      endfunction

      // Predicts the output beats of one accepted input beat.
      function void note_input(input bit [15:0] cur);
         bit [nrbs_pkg::POS_BITS-1:0] p;
         bit [nrbs_pkg::POS_BITS-1:0] stop;
         bit [31:0] w;
         bit [7:0] t;
         bit ended;
         p = pos;
         ended = 0;
         step_beats.delete();
         case (phase)
            nrbs_pkg::PH_BODY: begin
               body_beat(cur, p);
            end
            nrbs_pkg::PH_BANK1: begin
               w = header_word(cur);
               emit_unit(cur);
               stop = span_end(p, w);
               header_pos = stop;
               if (p == 1) event_len = stop;
               phase = nrbs_pkg::PH_BANK2;
            end
            nrbs_pkg::PH_BANK2: begin
               clear_hold();
               push_hold(cur);
               phase = nrbs_pkg::PH_BANK3;
            end
            nrbs_pkg::PH_BANK3: begin
               w = header_word(cur);
               emit_unit(cur);
               t = w[15:8];
               open_child(header_pos, t, holds_children(t), p);
            end
            nrbs_pkg::PH_SEG1: begin
               w = header_word(cur);
               emit_unit(cur);
               stop = span_end(p, {16'h0000, w[15:0]});
               if (data_type == nrbs_pkg::K_TAGSEG || data_type == nrbs_pkg::K_TAGSEG2)
                     begin
                  t = {4'h0, w[19:16]};
                  open_child(stop, t, t == nrbs_pkg::K_TAGSEG || t == nrbs_pkg::K_SEG
                             || t == nrbs_pkg::K_BANK, p);
               end else begin
                  t = w[23:16];
                  open_child(stop, t, holds_children(t), p);
               end
            end
            default: begin
               // First halfword of an event: no output yet.
               level = 0;
               clear_hold();
               push_hold(cur);
               phase = nrbs_pkg::PH_BANK1;
               pos = 1;
               return;
            end
         endcase
         pos = p + 1;
         if (pos == event_len) begin
            flush_held();
            level = 0;
            pos = '0;
            header_pos = '0;
            data_type = '0;
            phase = nrbs_pkg::PH_WAIT;
            ended = 1;
         end
         if (step_beats.size() > 0) begin
            step_beats[step_beats.size()-1].run_last = 1;
            step_beats[step_beats.size()-1].event_end = ended;
         end
         foreach (step_beats[i]) pending.push_back(step_beats[i]);
      endfunction

      function void check_output(input bit [15:0] half, input bit last, input bit eend,
                                 input bit bad);
         swap_beat_type e;
         if (pending.size() == 0) begin
            $error("unexpected output beat out_half=%h", half);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (half !== e.half) begin
            $error("out_half: expected %h, got %h", e.half, half);
            errors++;
         end
         if (last !== e.run_last) begin
            $error("run_last: expected %0d, got %0d", e.run_last, last);
            errors++;
         end
         if (eend !== e.event_end) begin
            $error("event_end: expected %0d, got %0d", e.event_end, eend);
            errors++;
         end
         if (bad !== e.bad_type) begin
            $error("bad_type: expected %0d, got %0d", e.bad_type, bad);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_in_half = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [15:0] rsp_out_half;
   logic rsp_run_last, rsp_event_end, rsp_bad_type;

   swap_scoreboard sb = new();
   bit quiet;
   bit chain_sent;
   int long_hold_req;
   int cycles;
   int sent;

   nested_record_byte_swapper u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_half(req_in_half),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_half(rsp_out_half),
      .rsp_run_last(rsp_run_last),
      .rsp_event_end(rsp_event_end),
      .rsp_bad_type(rsp_bad_type)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic int pick_wait();
      if (quiet) return 0;
      return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
   endfunction

   // Result side: checks each accepted beat and stalls at random.
   int stall_left;
   int long_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left = 0;
         long_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_output(rsp_out_half, rsp_run_last, rsp_event_end, rsp_bad_type);
            stall_left = pick_wait();
         end
         if (long_hold_req > 0) begin
            long_left = long_hold_req;
            long_hold_req = 0;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_stall <= 1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offers one input beat and waits until it is taken.
   task automatic send_half(input bit [15:0] h);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_in_half <= h;
      do @(posedge clock); while (req_stall);
      sb.note_input(h);
      sent++;
   endtask

   task automatic send_all(input half_q_type q);
      foreach (q[i]) send_half(q[i]);
   endtask

   function automatic void append(ref half_q_type dst, input half_q_type src);
      foreach (src[i]) dst.push_back(src[i]);
   endfunction

   // A 32-bit word as two halfwords in the foreign byte order.
   function automatic void add_word(ref half_q_type dst, input bit [31:0] w);
      dst.push_back(flip(w[31:16]));
      dst.push_back(flip(w[15:0]));
   endfunction

   function automatic half_q_type random_data(input int n);
      half_q_type q;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: q.push_back(16'h0000);
            1: q.push_back(16'hffff);
            default: q.push_back(16'($urandom));
         endcase
      end
      return q;
   endfunction

   function automatic bit [7:0] data_kind_pick();
      bit [7:0] known[18] = '{8'h00, 8'h03, 8'h06, 8'h07, 8'h36, 8'h37, 8'h04, 8'h05,
                              8'h30, 8'h34, 8'h35, 8'h01, 8'h02, 8'h0b, 8'h0f, 8'h08,
                              8'h09, 8'h0a};
      return known[$urandom_range(0, 17)];
   endfunction

   function automatic bit [7:0] nest_kind_pick();
      bit [7:0] kinds[9] = '{nrbs_pkg::K_TAGSEG, nrbs_pkg::K_SEG, nrbs_pkg::K_BANK,
                             nrbs_pkg::K_BANK2, nrbs_pkg::K_SEG2, nrbs_pkg::K_TAGSEG2,
                             8'h11, 8'h36, 8'h80};
      return kinds[$urandom_range(0, 8)];
   endfunction

   // Body of a container of the given kind, an even number of halfwords.
   function automatic half_q_type build_body(input bit [7:0] kind, input int depth);
      half_q_type q, sub;
      bit [7:0] t;
      bit nested;
      int n;
      int cnt;
      cnt = $urandom_range(0, 3);
      for (int c = 0; c < cnt; c++) begin
         if (kind == nrbs_pkg::K_TAGSEG || kind == nrbs_pkg::K_TAGSEG2) begin
            t = (depth > 0 && $urandom_range(0, 2) == 0) ? 8'($urandom_range(12, 14))
                                                        : {4'h0, 4'(data_kind_pick())};
            if (t == 8'h0c || t == 8'h0d || t == 8'h0e) nested = 1;
            else nested = 0;
         end else begin
            nested = depth > 0 && $urandom_range(0, 2) == 0;
            t = nested ? nest_kind_pick() : data_kind_pick();
         end
         if (kind == nrbs_pkg::K_BANK || kind == nrbs_pkg::K_BANK2 ||
             kind == nrbs_pkg::K_SEG || kind == nrbs_pkg::K_SEG2 ||
             kind == nrbs_pkg::K_TAGSEG || kind == nrbs_pkg::K_TAGSEG2) begin
            sub = nested ? build_body(t, depth - 1) : random_data(2 * $urandom_range(0, 4));
            if (kind == nrbs_pkg::K_BANK || kind == nrbs_pkg::K_BANK2) begin
               add_word(q, 32'(sub.size() / 2 + 1));
               add_word(q, {16'($urandom), t, 8'($urandom)});
            end else if (kind == nrbs_pkg::K_SEG || kind == nrbs_pkg::K_SEG2) begin
               add_word(q, {8'($urandom), t, 16'(sub.size() / 2)});
            end else begin
               add_word(q, {12'($urandom), t[3:0], 16'(sub.size() / 2)});
            end
            append(q, sub);
         end else begin
            // Packets: a count header and that many data halfwords.
            n = $urandom_range(0, 6);
            if (n == 0) q.push_back(16'h0000);
            else q.push_back(flip({8'($urandom), 8'(n)}));
            append(q, random_data(n));
         end
      end
      if (q.size() % 2 != 0) q.push_back(16'h0000);
      return q;
   endfunction

   // A chain of banks nested the given number of levels deep.
   function automatic half_q_type bank_chain(input int levels);
      half_q_type q, sub;
      if (levels == 0) return random_data(6);
      sub = bank_chain(levels - 1);
      add_word(q, 32'(sub.size() / 2 + 1));
      add_word(q, {16'($urandom), nrbs_pkg::K_BANK, 8'($urandom)});
      append(q, sub);
      return q;
   endfunction

   function automatic half_q_type build_event(input bit [7:0] kind, input half_q_type body);
      half_q_type q;
      add_word(q, 32'(body.size() / 2 + 1));
      add_word(q, {16'($urandom), kind, 8'($urandom)});
      append(q, body);
      return q;
   endfunction

   initial begin
      half_q_type ev;
      half_q_type blank;
      sb.reset_state();
      quiet = 1;
      chain_sent = 0;
      long_hold_req = 0;
      cycles = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // Directed: unknown packet data, empty packets, partial 8-byte unit,
      // an event that ends inside a header, and extreme halfwords.
      ev.delete();
      ev.push_back(flip(16'h0004));
      ev.push_back(16'h0000);
      ev.push_back(16'hffff);
      ev.push_back(16'h00ff);
      ev.push_back(16'hff00);
      ev.push_back(16'h0000);
      ev.push_back(16'h0000);
      ev = build_event(8'h11, ev);
      ev.push_back(16'h0000);
      send_all(ev);
      quiet = 0;
      ev.delete();
      add_word(ev, 32'h0000_0004);
      add_word(ev, {16'hffff, nrbs_pkg::K_BANK, 8'h00});
      add_word(ev, 32'h0000_0003);
      add_word(ev, {16'h0000, 8'h0a, 8'hff});
      append(ev, random_data(4));
      send_all(ev);
      ev.delete();
      add_word(ev, 32'h0000_0002);
      add_word(ev, {16'h1234, nrbs_pkg::K_SEG, 8'h01});
      ev.push_back(16'hffff);
      ev.push_back(16'h0000);
      send_all(ev);

      // Random well-formed events, with one that overflows the nesting stack
      // and one long hold on the result side.
      while (sent < 240) begin
         quiet = $urandom_range(0, 4) == 0;
         if (sent > 120 && !chain_sent && long_hold_req == 0 && long_left == 0) begin
            chain_sent = 1;
            long_hold_req = 300;
            ev = build_event(nrbs_pkg::K_BANK, bank_chain(17));
         end else begin
            ev = build_event(nest_kind_pick(), build_body(8'h00, 0));
            ev = build_event(nest_kind_pick() | 8'h00, blank);
            ev = build_event(nrbs_pkg::K_BANK, build_body(nrbs_pkg::K_BANK, 3));
            if ($urandom_range(0, 2) == 0) begin
               ev.delete();
               begin
                  bit [7:0] k;
                  half_q_type b;
                  k = nest_kind_pick();
                  b = build_body(k, 3);
                  ev = build_event(k, b);
               end
            end
         end
         send_all(ev);
      end

      // Broken streams: truncated events, bad lengths and raw noise.
      quiet = 0;
      for (int i = 0; i < 3; i++) begin
         ev = build_event(nrbs_pkg::K_SEG2, build_body(nrbs_pkg::K_SEG2, 2));
         ev[1] = flip(16'($urandom_range(1, 6)));
         send_all(ev);
      end
      ev = random_data(30);
      send_all(ev);

      req_valid <= 0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
